### hw/rtl/multi_stream_ring_audio_mixer_defines.svh
// assertion macros for the ring audio mixer
`ifndef MULTI_STREAM_RING_AUDIO_MIXER_DEFINES_SVH
`define MULTI_STREAM_RING_AUDIO_MIXER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSRAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mixer check failed");

// next-cycle implication, disabled during reset
`define MSRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mixer sequence check failed");

`endif

### hw/rtl/msram_pkg.sv
package msram_pkg;

	// sizing
	localparam int STREAMS    = 8;
	localparam int RING_DEPTH = 4096;
	localparam int SID_W      = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int MEM_DEPTH  = STREAMS * RING_DEPTH;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int FRAME_W    = 32;

	// arithmetic widths
	localparam int GAIN_W     = 9;
	localparam int PROD_W     = 26;
	localparam int SCALED_W   = PROD_W - 8;
	localparam int ACC_W      = 16 + SID_W + 2;
	localparam int VOL_MAX    = 100;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(70 * 256 / 100);
	localparam int LEVEL_W    = 13;

	// modes
	localparam logic [1:0] MODE_OPEN  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;
	localparam logic [1:0] MODE_MIX   = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         stream;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} in_word_t;

	typedef struct packed {
		logic               ok;
		logic [2:0]         stream_id;
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic [12:0]        level;
		logic               has_space;
	} out_word_t;

	// clamp a mixed sum to 16 bits
	function automatic logic signed [15:0] clamp16(input logic signed [ACC_W-1:0] v);
		logic signed [15:0] r;
		if (v > ACC_W'(32767))
			r = 16'sd32767;
		else if (v < -ACC_W'(32768))
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

	// ring pointer advance with wrap
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

endpackage

### hw/rtl/msram_ram.sv
module msram_ram
	import msram_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [FRAME_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [FRAME_W-1:0] rd_data
);

	logic [FRAME_W-1:0] mem [MEM_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

### hw/rtl/multi_stream_ring_audio_mixer.sv
// open, write and close: the result passes through the exec and done states to the output register
// mix: the exec state, then a walk with at most one frame store read per stream slot
//   plus a read and scale tail through the read and product registers, set by the single read port
// one word in flight; the next word is taken while a result waits
// reset clears stream state and sets volume to 70; the frame store is not cleared
`include "multi_stream_ring_audio_mixer_defines.svh"

module multi_stream_ring_audio_mixer
	import msram_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_MIX  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int MC_W = $clog2(STREAMS + 2);
	localparam logic [MC_W-1:0] MIX_LAST = MC_W'(STREAMS + 1);

	logic [1:0]        state_q;
	in_word_t          req_q;
	logic [GAIN_W-1:0] gain_q;

	// per-stream control
	logic [PTR_W-1:0] wp_q    [STREAMS];
	logic [PTR_W-1:0] rp_q    [STREAMS];
	logic [CNT_W-1:0] cnt_q   [STREAMS];
	logic             use_q   [STREAMS];
	logic             close_q [STREAMS];

	logic              ok_q;
	logic [2:0]        id_q;
	logic              rep_valid_q;
	logic [SID_W-1:0]  rep_sid_q;
	logic [MC_W-1:0]   mix_cnt_q;
	logic signed [ACC_W-1:0] accl_q, accr_q;

	logic                     pop_s1;
	logic                     pop_s2;
	logic signed [PROD_W-1:0] prodl_s2, prodr_s2;

	logic            out_valid_q;
	out_word_t       out_q;

	// volume to gain: floor(v*256/100) through a reciprocal multiply
	logic [6:0]  vol_sat;
	logic [27:0] gain_prod;
	assign vol_sat   = (cfg_wr_data > 7'(VOL_MAX)) ? 7'(VOL_MAX) : cfg_wr_data;
	assign gain_prod = {13'b0, vol_sat, 8'b0} * 28'd5243;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gain_q <= GAIN_RESET;
		else if (cfg_wr_en)
			gain_q <= gain_prod[27:19];
	end

	// addressed stream of the current word
	logic             addr_ok;
	logic [SID_W-1:0] sid;
	assign addr_ok = (32'(req_q.stream) < STREAMS);
	assign sid     = addr_ok ? SID_W'(req_q.stream) : '0;

	// lowest free stream
	logic             free_found;
	logic [SID_W-1:0] free_sid;
	always_comb begin
		free_found = 1'b0;
		free_sid   = '0;
		for (int i = STREAMS - 1; i >= 0; i--) begin
			if (!use_q[i]) begin
				free_found = 1'b1;
				free_sid   = SID_W'(i);
			end
		end
	end

	// stream walked by a mix
	logic             mix_active;
	logic [SID_W-1:0] mix_sid;
	logic             mix_hit;
	logic             mix_last;
	assign mix_active = (state_q == ST_MIX) && (32'(mix_cnt_q) < STREAMS);
	assign mix_sid    = (32'(mix_cnt_q) < STREAMS) ? SID_W'(mix_cnt_q) : '0;
	assign mix_hit    = mix_active && use_q[mix_sid] && (cnt_q[mix_sid] != '0);
	assign mix_last   = (state_q == ST_MIX) && (mix_cnt_q == MIX_LAST);

	// frame store ports
	logic               wr_ok;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [FRAME_W-1:0] ram_rdata;
	assign wr_ok = addr_ok && use_q[sid] && !close_q[sid] &&
		(cnt_q[sid] < CNT_W'(RING_DEPTH));
	assign ram_we    = (state_q == ST_EXEC) && (req_q.mode == MODE_WRITE) && wr_ok;
	assign ram_waddr = ADDR_W'(32'(sid) * RING_DEPTH + 32'(wp_q[sid]));
	assign ram_raddr = ADDR_W'(32'(mix_sid) * RING_DEPTH + 32'(rp_q[mix_sid]));

	msram_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data ({req_q.right_sample, req_q.left_sample}),
		.rd_en   (mix_hit),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// scale tail: multiply, then truncate toward zero and accumulate
	logic signed [15:0]       rd_l, rd_r;
	logic signed [SCALED_W-1:0] scl, scr;
	assign rd_l = ram_rdata[15:0];
	assign rd_r = ram_rdata[31:16];
	assign scl  = SCALED_W'((prodl_s2 + (prodl_s2[PROD_W-1] ? PROD_W'(255) : PROD_W'(0)))
		>>> 8);
	assign scr  = SCALED_W'((prodr_s2 + (prodr_s2[PROD_W-1] ? PROD_W'(255) : PROD_W'(0)))
		>>> 8);

	always_ff @(posedge clk) begin
		prodl_s2 <= PROD_W'(rd_l * $signed({1'b0, gain_q}));
		prodr_s2 <= PROD_W'(rd_r * $signed({1'b0, gain_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1 <= 1'b0;
			pop_s2 <= 1'b0;
		end else begin
			pop_s1 <= mix_hit;
			pop_s2 <= pop_s1;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// sequencer and stream state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mix_cnt_q   <= '0;
			ok_q        <= 1'b0;
			id_q        <= '0;
			rep_valid_q <= 1'b0;
			rep_sid_q   <= '0;
			for (int i = 0; i < STREAMS; i++) begin
				wp_q[i]    <= '0;
				rp_q[i]    <= '0;
				cnt_q[i]   <= '0;
				use_q[i]   <= 1'b0;
				close_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// mix walks the streams, the other modes report at once
					state_q <= (req_q.mode == MODE_MIX) ? ST_MIX : ST_DONE;
					unique case (req_q.mode)
						MODE_OPEN: begin
							ok_q        <= free_found;
							id_q        <= free_found ? 3'(free_sid) : 3'd0;
							rep_valid_q <= free_found;
							rep_sid_q   <= free_sid;
							if (free_found) begin
								use_q[free_sid]   <= 1'b1;
								close_q[free_sid] <= 1'b0;
								wp_q[free_sid]    <= '0;
								rp_q[free_sid]    <= '0;
								cnt_q[free_sid]   <= '0;
							end
						end
						MODE_WRITE: begin
							ok_q        <= wr_ok;
							id_q        <= '0;
							rep_valid_q <= addr_ok;
							rep_sid_q   <= sid;
							if (wr_ok) begin
								wp_q[sid]  <= advance(wp_q[sid]);
								cnt_q[sid] <= cnt_q[sid] + CNT_W'(1);
							end
						end
						MODE_CLOSE: begin
							ok_q        <= addr_ok && use_q[sid] && !close_q[sid];
							id_q        <= '0;
							rep_valid_q <= addr_ok;
							rep_sid_q   <= sid;
							if (addr_ok && use_q[sid] && !close_q[sid]) begin
								if (cnt_q[sid] == '0)
									use_q[sid] <= 1'b0;
								else
									close_q[sid] <= 1'b1;
							end
						end
						MODE_MIX: begin
							ok_q        <= 1'b1;
							id_q        <= '0;
							rep_valid_q <= addr_ok;
							rep_sid_q   <= sid;
							mix_cnt_q   <= '0;
						end
						default: ;
					endcase
				end
				ST_MIX: begin
					mix_cnt_q <= mix_cnt_q + MC_W'(1);
					if (mix_hit) begin
						rp_q[mix_sid]  <= advance(rp_q[mix_sid]);
						cnt_q[mix_sid] <= cnt_q[mix_sid] - CNT_W'(1);
					end
					// closing stream drained by this pop or already empty
					if (mix_active && close_q[mix_sid] &&
						(cnt_q[mix_sid] == '0 || (mix_hit && cnt_q[mix_sid] == CNT_W'(1)))) begin
						use_q[mix_sid]   <= 1'b0;
						close_q[mix_sid] <= 1'b0;
					end
					if (mix_cnt_q == MIX_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input capture and accumulators
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			req_q <= in_word;
		if (state_q == ST_EXEC) begin
			accl_q <= '0;
			accr_q <= '0;
		end else if (pop_s2) begin
			accl_q <= accl_q + ACC_W'(scl);
			accr_q <= accr_q + ACC_W'(scr);
		end
	end

	// result assembly
	out_word_t res;
	logic [CNT_W-1:0] rep_cnt;
	assign rep_cnt = cnt_q[rep_sid_q];
	always_comb begin
		res.ok        = ok_q;
		res.stream_id = id_q;
		res.left_out  = (req_q.mode == MODE_MIX) ? clamp16(accl_q) : 16'sd0;
		res.right_out = (req_q.mode == MODE_MIX) ? clamp16(accr_q) : 16'sd0;
		res.level     = rep_valid_q ? LEVEL_W'(rep_cnt) : '0;
		res.has_space = rep_valid_q && (rep_cnt < CNT_W'(RING_DEPTH));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && (!out_valid_q || !out_stall))
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall))
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// checks
	`MSRAM_ASSERT_NOW(a_free_empty, clk, arst_n, !use_q[mix_sid], cnt_q[mix_sid] == '0)
	`MSRAM_ASSERT_NOW(a_close_used, clk, arst_n, close_q[mix_sid], use_q[mix_sid])
	`MSRAM_ASSERT_NEXT(a_mix_end, clk, arst_n, mix_last, state_q == ST_DONE && !pop_s2)

endmodule
